>>> rtl/core/hbridge_drive_with_startup_check_assert.svh
// Assertion macros for the H-bridge drive block.
// Included by the top level; no other dependencies.
`ifndef HBRIDGE_DRIVE_WITH_STARTUP_CHECK_ASSERT_SVH
`define HBRIDGE_DRIVE_WITH_STARTUP_CHECK_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define HBD_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define HBD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/core/hbd_pkg.sv
// Shared types and constants for the H-bridge drive block.
// No dependencies.
package hbd_pkg;

   // transaction action codes
   localparam logic [1:0] ACT_TICK  = 2'd0;
   localparam logic [1:0] ACT_START = 2'd1;
   localparam logic [1:0] ACT_FORCE = 2'd2;

   // force direction codes; anything else is neutral
   localparam logic [1:0] DIR_LEFT  = 2'd1;
   localparam logic [1:0] DIR_RIGHT = 2'd2;

   // register file
   localparam int         CSR_ADDR_BITS       = 3;
   localparam int         CSR_DATA_BITS       = 32;
   localparam logic       CSR_PHASE_TICKS     = 1'b0;
   localparam logic       CSR_CHECK_INTENSITY = 1'b1;
   localparam logic [15:0] PHASE_TICKS_RESET     = 16'd1000;
   localparam logic [6:0]  CHECK_INTENSITY_RESET = 7'd50;

   // duty = pct * 255 / 100, with the divide done as multiply by ceil(2^19/100)
   localparam logic [6:0]  PCT_MAX    = 7'd100;
   localparam logic [20:0] DUTY_SCALE = 21'd1336965;
   localparam int          DUTY_SHIFT = 19;

   typedef enum logic [3:0] {
      PH_LEFT  = 4'b0001,
      PH_RIGHT = 4'b0010,
      PH_STOP  = 4'b0100,
      PH_DONE  = 4'b1000
   } phase_type;

   typedef struct packed {
      logic [15:0] phase_ticks;
      logic [6:0]  check_intensity;
   } cfg_type;

   typedef struct packed {
      logic [1:0]         action;
      logic [1:0]         direction;
      logic signed [15:0] intensity;
   } req_type;

   typedef struct packed {
      logic [7:0] left_duty;
      logic [7:0] right_duty;
      logic       bridge_on;
      logic       checking;
      logic       ready_res;
      logic       command_taken;
   } rsp_type;

endpackage

>>> rtl/core/hbd_duty.sv
// Intensity percent to PWM duty: clamp to 0..100, scale by 255/100, truncate.
// Depends on hbd_pkg.
module hbd_duty (
   input  logic signed [15:0] pct,
   output logic [7:0]         duty
);
   import hbd_pkg::*;

   logic [6:0]  pct_clamped;
   logic [27:0] scaled;

   always_comb begin
      if (pct < 16'sd0) begin
         pct_clamped = '0;
      end else if (pct > $signed({9'd0, PCT_MAX})) begin
         pct_clamped = PCT_MAX;
      end else begin
         pct_clamped = pct[6:0];
      end
   end

   // exact for every product up to 25500
   assign scaled = 28'(pct_clamped) * 28'(DUTY_SCALE);
   assign duty   = scaled[DUTY_SHIFT +: 8];

endmodule

>>> rtl/core/hbd_csr.sv
// Configuration registers of the H-bridge drive block behind an APB-style port.
// Depends on hbd_pkg.
module hbd_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [hbd_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [hbd_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [hbd_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output hbd_pkg::cfg_type                   cfg
);
   import hbd_pkg::*;

   logic        wr_en;
   logic        reg_sel;
   logic [15:0] phase_ticks_ff, phase_ticks_in;
   logic [6:0]  check_intensity_ff, check_intensity_in;

   assign wr_en   = csr_psel && csr_penable && csr_pwrite;
   assign reg_sel = csr_paddr[2];

   always_comb begin
      phase_ticks_in     = phase_ticks_ff;
      check_intensity_in = check_intensity_ff;
      if (wr_en) begin
         unique case (reg_sel)
            CSR_PHASE_TICKS:     phase_ticks_in     = csr_pwdata[15:0];
            CSR_CHECK_INTENSITY: check_intensity_in = csr_pwdata[6:0];
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ticks_ff     <= PHASE_TICKS_RESET;
         check_intensity_ff <= CHECK_INTENSITY_RESET;
      end else begin
         phase_ticks_ff     <= phase_ticks_in;
         check_intensity_ff <= check_intensity_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         CSR_PHASE_TICKS:     csr_prdata = CSR_DATA_BITS'(phase_ticks_ff);
         CSR_CHECK_INTENSITY: csr_prdata = CSR_DATA_BITS'(check_intensity_ff);
      endcase
   end

   assign cfg.phase_ticks     = phase_ticks_ff;
   assign cfg.check_intensity = check_intensity_ff;

endmodule

>>> rtl/core/hbd_core.sv
// Drive state and self-check sequencer: applies one transaction per cycle in which item_fire is high.
// Depends on hbd_pkg and hbd_duty.
module hbd_core #(
   parameter int TIMER_BITS = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             item_fire,
   input  hbd_pkg::req_type item,
   input  hbd_pkg::cfg_type cfg,
   output hbd_pkg::rsp_type result
);
   import hbd_pkg::*;

   localparam int LIMIT_BITS = (TIMER_BITS > 16) ? TIMER_BITS : 16;
   localparam logic [TIMER_BITS-1:0] COUNT_MAX = {TIMER_BITS{1'b1}};

   phase_type             phase_ff, phase_in;
   logic [TIMER_BITS-1:0] count_ff, count_in;
   logic                  running_ff, running_in;
   logic                  finished_ff, finished_in;
   logic                  drive_en_ff, drive_en_in;
   logic                  bridge_ff, bridge_in;
   logic [7:0]            left_ff, left_in;
   logic [7:0]            right_ff, right_in;
   logic                  taken;

   logic [7:0]            check_duty;
   logic [7:0]            force_duty;
   logic [LIMIT_BITS-1:0] ticks_ext;
   logic [LIMIT_BITS-1:0] limit;
   logic [TIMER_BITS-1:0] count_inc;
   logic                  phase_end;

   hbd_duty u_check_duty (
      .pct  ($signed({9'd0, cfg.check_intensity})),
      .duty (check_duty)
   );

   hbd_duty u_force_duty (
      .pct  (item.intensity),
      .duty (force_duty)
   );

   // clip the phase length to what the counter can reach; saturate the counter
   assign ticks_ext = LIMIT_BITS'(cfg.phase_ticks);
   assign limit     = (ticks_ext > LIMIT_BITS'(COUNT_MAX)) ? LIMIT_BITS'(COUNT_MAX) : ticks_ext;
   assign count_inc = (count_ff == COUNT_MAX) ? count_ff : count_ff + TIMER_BITS'(1);
   assign phase_end = LIMIT_BITS'(count_inc) >= limit;

   always_comb begin
      phase_in    = phase_ff;
      count_in    = count_ff;
      running_in  = running_ff;
      finished_in = finished_ff;
      drive_en_in = drive_en_ff;
      bridge_in   = bridge_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      taken       = 1'b0;
      case (item.action)
         ACT_TICK: begin
            if (running_ff) begin
               if (phase_end) begin
                  count_in = '0;
                  left_in  = '0;
                  right_in = '0;
                  unique case (phase_ff)
                     PH_LEFT: begin
                        phase_in = PH_RIGHT;
                        right_in = check_duty;
                     end
                     PH_RIGHT: phase_in = PH_STOP;
                     PH_STOP: begin
                        phase_in    = PH_DONE;
                        running_in  = 1'b0;
                        finished_in = 1'b1;
                        drive_en_in = 1'b1;
                     end
                     default: phase_in = PH_LEFT;
                  endcase
               end else begin
                  count_in = count_inc;
               end
            end
         end
         ACT_START: begin
            bridge_in   = 1'b1;
            running_in  = 1'b1;
            finished_in = 1'b0;
            phase_in    = PH_LEFT;
            count_in    = '0;
            left_in     = check_duty;
            right_in    = '0;
         end
         ACT_FORCE: begin
            // drop force commands until a check has completed and none runs
            if (drive_en_ff && !running_ff) begin
               taken    = 1'b1;
               left_in  = '0;
               right_in = '0;
               if (item.direction == DIR_LEFT) begin
                  left_in = force_duty;
               end else if (item.direction == DIR_RIGHT) begin
                  right_in = force_duty;
               end
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_LEFT;
         count_ff    <= '0;
         running_ff  <= 1'b0;
         finished_ff <= 1'b0;
         drive_en_ff <= 1'b0;
         bridge_ff   <= 1'b0;
         left_ff     <= '0;
         right_ff    <= '0;
      end else if (item_fire) begin
         phase_ff    <= phase_in;
         count_ff    <= count_in;
         running_ff  <= running_in;
         finished_ff <= finished_in;
         drive_en_ff <= drive_en_in;
         bridge_ff   <= bridge_in;
         left_ff     <= left_in;
         right_ff    <= right_in;
      end
   end

   assign result.left_duty     = left_in;
   assign result.right_duty    = right_in;
   assign result.bridge_on     = bridge_in;
   assign result.checking      = running_in;
   assign result.ready_res     = drive_en_in && finished_in;
   assign result.command_taken = taken;

endmodule

>>> rtl/core/hbridge_drive_with_startup_check.sv
// H-bridge drive with timed startup self-check. Accepts one transaction per
// clock cycle while the input register is empty or the result register is
// free, and presents one result per transaction on the rsp_ ports. A taken
// transaction waits in the input register until the result register is free;
// the core updates the state as it moves on, and its result is held until read.
// Configuration must be written through the csr_ port only while no transaction
// is in flight; the block does not enforce this. No clearing pass follows reset.
// Depends on hbd_pkg, hbd_csr, hbd_core and the assertion macro header.
`include "hbridge_drive_with_startup_check_assert.svh"

module hbridge_drive_with_startup_check #(
   parameter int TIMER_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [1:0]                         req_action,
   input  logic [1:0]                         req_direction,
   input  logic signed [15:0]                 req_intensity,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_left_duty,
   output logic [7:0]                         rsp_right_duty,
   output logic                               rsp_bridge_on,
   output logic                               rsp_checking,
   output logic                               rsp_ready_res,
   output logic                               rsp_command_taken,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [hbd_pkg::CSR_ADDR_BITS-1:0]  csr_paddr,
   input  logic [hbd_pkg::CSR_DATA_BITS-1:0]  csr_pwdata,
   output logic [hbd_pkg::CSR_DATA_BITS-1:0]  csr_prdata,
   output logic                               csr_pready
);
   import hbd_pkg::*;

   cfg_type cfg;
   req_type req_item;
   req_type item_ff, item_in;
   logic    item_valid_ff, item_valid_in;
   rsp_type result;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    out_free;
   logic    item_fire;

   assign csr_pready = 1'b1;

   hbd_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .cfg         (cfg)
   );

   assign req_item.action    = req_action;
   assign req_item.direction = req_direction;
   assign req_item.intensity = req_intensity;

   // the result register frees up when empty or being read this cycle
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign item_fire = item_valid_ff && out_free;
   assign req_ready = !item_valid_ff || out_free;

   assign item_valid_in = req_ready ? req_valid : item_valid_ff;
   assign item_in       = (req_valid && req_ready) ? req_item : item_ff;
   assign rsp_valid_in  = out_free ? item_valid_ff : rsp_valid_ff;
   assign rsp_in        = item_fire ? result : rsp_ff;

   hbd_core #(
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .clock     (clock),
      .reset     (reset),
      .item_fire (item_fire),
      .item      (item_ff),
      .cfg       (cfg),
      .result    (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_left_duty     = rsp_ff.left_duty;
   assign rsp_right_duty    = rsp_ff.right_duty;
   assign rsp_bridge_on     = rsp_ff.bridge_on;
   assign rsp_checking      = rsp_ff.checking;
   assign rsp_ready_res     = rsp_ff.ready_res;
   assign rsp_command_taken = rsp_ff.command_taken;

   `HBD_ASSERT_IMPLY(a_taken_only_when_ready, clock, reset, rsp_valid && rsp_command_taken, !rsp_checking && rsp_ready_res, "force applied while not ready")
   `HBD_ASSERT_IMPLY(a_check_has_bridge, clock, reset, rsp_valid && rsp_checking, rsp_bridge_on, "check running with bridge off")
   `HBD_ASSERT_IMPLY(a_ready_not_checking, clock, reset, rsp_valid && rsp_ready_res, !rsp_checking, "ready while check runs")
   `HBD_ASSERT_NEXT(a_pending_item_kept, clock, reset, item_valid_ff && !out_free, item_valid_ff && $stable(item_ff), "input register lost a stalled item")

endmodule

>>> tb/sv/testbench.sv
// Self-checking testbench for hbridge_drive_with_startup_check: directed and
// random transactions, an in-line prediction of every result, and checks on
// the result stream and on register readback. Depends on hbd_pkg and the RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import hbd_pkg::*;

   localparam logic [1:0] ACT_NOP     = 2'd3;
   localparam logic [1:0] DIR_NEUTRAL = 2'd0;
   localparam logic [1:0] DIR_SPARE   = 2'd3;
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_PHASE_TICKS     = {CSR_PHASE_TICKS, 2'b00};
   localparam logic [CSR_ADDR_BITS-1:0] ADDR_CHECK_INTENSITY = {CSR_CHECK_INTENSITY, 2'b00};
   localparam int QUIET_LIMIT = 2000;
   localparam int MAX_PRINTS  = 100;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic [1:0]                req_action = ACT_TICK;
   logic [1:0]                req_direction = DIR_NEUTRAL;
   logic signed [15:0]        req_intensity = '0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [7:0]                rsp_left_duty;
   logic [7:0]                rsp_right_duty;
   logic                      rsp_bridge_on;
   logic                      rsp_checking;
   logic                      rsp_ready_res;
   logic                      rsp_command_taken;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [CSR_ADDR_BITS-1:0]  csr_paddr = '0;
   logic [CSR_DATA_BITS-1:0]  csr_pwdata = '0;
   logic [CSR_DATA_BITS-1:0]  csr_prdata;
   logic                      csr_pready;

   req_type     cmd_backlog[$];
   rsp_type     outputs_due[$];
   int unsigned send_gap_pct = 0;
   int unsigned stall_pct = 0;
   int          fail_count = 0;
   int          quiet_cycles = 0;

   // shadow copy of the drive state and its registers
   cfg_type     drive_cfg;
   phase_type   check_step;
   logic [15:0] step_ticks;
   logic        check_busy;
   logic        check_done;
   logic        drive_unlocked;
   logic        bridge_en;
   logic [7:0]  left_lvl;
   logic [7:0]  right_lvl;

   hbridge_drive_with_startup_check dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_action        (req_action),
      .req_direction     (req_direction),
      .req_intensity     (req_intensity),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_left_duty     (rsp_left_duty),
      .rsp_right_duty    (rsp_right_duty),
      .rsp_bridge_on     (rsp_bridge_on),
      .rsp_checking      (rsp_checking),
      .rsp_ready_res     (rsp_ready_res),
      .rsp_command_taken (rsp_command_taken),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_prdata        (csr_prdata),
      .csr_pready        (csr_pready)
   );

   initial forever #1 clock = ~clock;

   task automatic report_error(string msg);
      fail_count++;
      if (fail_count <= MAX_PRINTS) begin
         $display("ERROR @%0t: %s", $time, msg);
      end
   endtask

   task automatic check_field(string name, logic [31:0] got, logic [31:0] want);
      if (got !== want) begin
         report_error($sformatf("%s: got %0h, want %0h", name, got, want));
      end
   endtask

   function automatic logic [7:0] pct_to_duty(int pct);
      if (pct < 0) pct = 0;
      if (pct > 100) pct = 100;
      return 8'((pct * 255) / 100);
   endfunction

   // Apply one transaction to the shadow state and return the outputs after it.
   function automatic rsp_type bridge_step(req_type cmd);
      rsp_type outs;
      logic    taken;
      logic [7:0] duty;
      taken = 1'b0;
      case (cmd.action)
         ACT_TICK: begin
            if (check_busy) begin
               if (step_ticks != 16'hFFFF) step_ticks = step_ticks + 16'd1;
               // a phase length of zero ends the phase on every tick
               if (step_ticks >= drive_cfg.phase_ticks) begin
                  step_ticks = '0;
                  if (check_step == PH_LEFT) begin
                     check_step = PH_RIGHT;
                     left_lvl = '0;
                     right_lvl = pct_to_duty(drive_cfg.check_intensity);
                  end else begin
                     check_step = (check_step == PH_RIGHT) ? PH_STOP : PH_DONE;
                     left_lvl = '0;
                     right_lvl = '0;
                     if (check_step == PH_DONE) begin
                        check_busy = 1'b0;
                        check_done = 1'b1;
                        drive_unlocked = 1'b1;
                     end
                  end
               end
            end
         end
         ACT_START: begin
            bridge_en = 1'b1;
            check_busy = 1'b1;
            check_done = 1'b0;
            check_step = PH_LEFT;
            step_ticks = '0;
            left_lvl = pct_to_duty(drive_cfg.check_intensity);
            right_lvl = '0;
         end
         ACT_FORCE: begin
            if (drive_unlocked && !check_busy) begin
               taken = 1'b1;
               duty = pct_to_duty(cmd.intensity);
               case (cmd.direction)
                  DIR_LEFT: begin
                     left_lvl = duty;
                     right_lvl = '0;
                  end
                  DIR_RIGHT: begin
                     right_lvl = duty;
                     left_lvl = '0;
                  end
                  default: begin
                     left_lvl = '0;
                     right_lvl = '0;
                  end
               endcase
            end
         end
         default: ;
      endcase
      outs.left_duty = left_lvl;
      outs.right_duty = right_lvl;
      outs.bridge_on = bridge_en;
      outs.checking = check_busy;
      outs.ready_res = drive_unlocked && check_done;
      outs.command_taken = taken;
      return outs;
   endfunction

   // Driver: present backlog transactions, predict each one as it is accepted.
   always @(posedge clock) begin : feed_commands
      req_type taken_cmd;
      req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            taken_cmd.action = req_action;
            taken_cmd.direction = req_direction;
            taken_cmd.intensity = req_intensity;
            outputs_due.push_back(bridge_step(taken_cmd));
         end
         if (!req_valid || req_ready) begin
            if (cmd_backlog.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               nxt = cmd_backlog.pop_front();
               req_valid <= 1'b1;
               req_action <= nxt.action;
               req_direction <= nxt.direction;
               req_intensity <= nxt.intensity;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Monitor: compare each accepted result against the oldest prediction.
   always @(posedge clock) begin : watch_results
      rsp_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (outputs_due.size() == 0) begin
               report_error("result with no transaction waiting for it");
            end else begin
               want = outputs_due.pop_front();
               check_field("left_duty", rsp_left_duty, want.left_duty);
               check_field("right_duty", rsp_right_duty, want.right_duty);
               check_field("bridge_on", rsp_bridge_on, want.bridge_on);
               check_field("checking", rsp_checking, want.checking);
               check_field("ready_res", rsp_ready_res, want.ready_res);
               check_field("command_taken", rsp_command_taken, want.command_taken);
            end
         end
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin : watchdog
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_psel) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == QUIET_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic add_item(logic [1:0] act, logic [1:0] dir, logic signed [15:0] pct);
      req_type cmd;
      cmd.action = act;
      cmd.direction = dir;
      cmd.intensity = pct;
      cmd_backlog.push_back(cmd);
   endtask

   function automatic logic signed [15:0] pick_intensity();
      logic [15:0] raw;
      int          near;
      raw = 16'($urandom);
      near = int'($urandom_range(500)) - 200;
      case ($urandom_range(3))
         0: return raw;
         1: return 16'($urandom_range(100));
         2: begin
            case ($urandom_range(5))
               0: return 16'sh8000;
               1: return -16'sd1;
               2: return 16'sd0;
               3: return 16'sd100;
               4: return 16'sd101;
               default: return 16'sh7FFF;
            endcase
         end
         default: return near[15:0];
      endcase
   endfunction

   // Mostly full start/tick/force sessions so the check can complete and forces
   // land; the rest is raw noise across every action and direction code.
   task automatic queue_sessions(int n);
      int added;
      int span;
      int run;
      int k;
      added = 0;
      span = (drive_cfg.phase_ticks == 0) ? 1 : int'(drive_cfg.phase_ticks);
      while (added < n) begin
         if ($urandom_range(99) < 70) begin
            add_item(ACT_START, 2'($urandom), pick_intensity());
            run = (span > 20) ? $urandom_range(40, 5) : 3 * span - 1 + $urandom_range(2);
            for (k = 0; k < run; k++) begin
               case ($urandom_range(39))
                  0: add_item(ACT_START, 2'($urandom), pick_intensity());
                  1, 2, 3: add_item(ACT_FORCE, 2'($urandom), pick_intensity());
                  default: add_item(ACT_TICK, 2'($urandom), pick_intensity());
               endcase
            end
            added += 1 + run;
            run = $urandom_range(10, 2);
            for (k = 0; k < run; k++) begin
               case ($urandom_range(9))
                  0: add_item(ACT_TICK, 2'($urandom), pick_intensity());
                  1: add_item(ACT_NOP, 2'($urandom), pick_intensity());
                  default: add_item(ACT_FORCE, 2'($urandom), pick_intensity());
               endcase
            end
            added += run;
         end else begin
            add_item(2'($urandom), 2'($urandom), pick_intensity());
            added++;
         end
      end
   endtask

   task automatic wait_drained();
      while (cmd_backlog.size() != 0 || req_valid || outputs_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_BITS-1:0] addr, logic [CSR_DATA_BITS-1:0] value);
      @(posedge clock);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      // read it back
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field($sformatf("readback at %0h", addr), csr_prdata, value);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic begin_phase(logic [15:0] ticks, logic [6:0] pct, int unsigned gap,
                              int unsigned stall);
      wait_drained();
      csr_write(ADDR_PHASE_TICKS, {16'd0, ticks});
      csr_write(ADDR_CHECK_INTENSITY, {25'd0, pct});
      drive_cfg.phase_ticks = ticks;
      drive_cfg.check_intensity = pct;
      send_gap_pct = gap;
      stall_pct = stall;
   endtask

   initial begin
      drive_cfg.phase_ticks = PHASE_TICKS_RESET;
      drive_cfg.check_intensity = CHECK_INTENSITY_RESET;
      check_step = PH_LEFT;
      step_ticks = '0;
      check_busy = 1'b0;
      check_done = 1'b0;
      drive_unlocked = 1'b0;
      bridge_en = 1'b0;
      left_lvl = '0;
      right_lvl = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed: one tick per phase so the whole check is short
      begin_phase(16'd1, 7'd100, 0, 0);
      add_item(ACT_TICK, DIR_LEFT, 16'sd10);        // idle tick
      add_item(ACT_FORCE, DIR_LEFT, 16'sd50);       // not ready yet
      add_item(ACT_NOP, DIR_RIGHT, 16'sd20);
      add_item(ACT_START, DIR_NEUTRAL, 16'sd0);
      add_item(ACT_TICK, DIR_NEUTRAL, 16'sd0);
      add_item(ACT_FORCE, DIR_RIGHT, 16'sd100);     // dropped during the check
      add_item(ACT_START, DIR_NEUTRAL, 16'sd0);     // restart at left
      add_item(ACT_TICK, DIR_NEUTRAL, 16'sd0);
      add_item(ACT_TICK, DIR_NEUTRAL, 16'sd0);
      add_item(ACT_TICK, DIR_NEUTRAL, 16'sd0);
      add_item(ACT_TICK, DIR_NEUTRAL, 16'sd0);      // idle again
      add_item(ACT_FORCE, DIR_LEFT, 16'sh7FFF);
      add_item(ACT_FORCE, DIR_RIGHT, 16'sh8000);
      add_item(ACT_FORCE, DIR_LEFT, 16'sd100);
      add_item(ACT_FORCE, DIR_RIGHT, 16'sd101);
      add_item(ACT_FORCE, DIR_LEFT, -16'sd1);
      add_item(ACT_FORCE, DIR_NEUTRAL, 16'sd77);
      add_item(ACT_FORCE, DIR_SPARE, 16'sd50);
      add_item(ACT_FORCE, DIR_RIGHT, 16'sd1);
      add_item(ACT_FORCE, DIR_LEFT, 16'sd99);
      add_item(ACT_NOP, DIR_SPARE, 16'shFFFF);
      add_item(ACT_START, DIR_LEFT, 16'sd30);       // ready drops again
      add_item(ACT_TICK, DIR_NEUTRAL, 16'sd0);
      add_item(ACT_TICK, DIR_NEUTRAL, 16'sd0);
      add_item(ACT_TICK, DIR_NEUTRAL, 16'sd0);

      begin_phase(16'd0, 7'd127, 60, 0);
      queue_sessions(200);
      begin_phase(16'd3, 7'd0, 0, 60);
      queue_sessions(100);
      wait_drained();
      queue_sessions(100);
      begin_phase(16'd2, 7'd1, 10, 10);
      queue_sessions(200);
      begin_phase(16'd65535, 7'd37, 0, 0);
      queue_sessions(50);
      begin_phase(16'd5, 7'd100, 60, 60);
      queue_sessions(150);

      wait_drained();
      repeat (10) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
